FILE: hw/rtl/udp_connection_tracker_top_assert.svh
// Assertion macros for the UDP connection tracker.
`ifndef UDP_CONNECTION_TRACKER_TOP_ASSERT_SVH
`define UDP_CONNECTION_TRACKER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset.
`define UTP_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("utp assertion failed");

// Check that a condition in one cycle is followed by another in the next.
`define UTP_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("utp assertion failed");

`else

`define UTP_ASSERT(name, prop)
`define UTP_ASSERT_NEXT(name, pre, post)

`endif

`endif

FILE: hw/rtl/utp_pkg.sv
// Shared types, constants and helpers of the UDP connection tracker.
package utp_pkg;

  localparam int PENDING_SLOTS    = 16;
  localparam int CONNECTION_SLOTS = 16;
  localparam int AGE_BITS         = 16;
  localparam int PEER_W           = 48;
  localparam int NUM_W            = 32;
  localparam int CFG_W            = 16;
  localparam int CNT_W            = $clog2(CONNECTION_SLOTS + 1);
  localparam int CMP_W            = (AGE_BITS > CFG_W) ? AGE_BITS : CFG_W;

  typedef logic [AGE_BITS-1:0] age_t;
  typedef logic [PEER_W-1:0]   peer_t;
  typedef logic [NUM_W-1:0]    num_t;
  typedef logic [CFG_W-1:0]    cfg_t;

  localparam logic [2:0] MSG_JOIN_REQ  = 3'd0;
  localparam logic [2:0] MSG_JOIN_ACK  = 3'd1;
  localparam logic [2:0] MSG_HEARTBEAT = 3'd2;
  localparam logic [2:0] MSG_PAYLOAD   = 3'd3;
  localparam logic [2:0] MSG_LIST_REQ  = 3'd4;

  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic [1:0] CFG_PROTOCOL_VERSION = 2'd0;
  localparam logic [1:0] CFG_PENDING_TIMEOUT  = 2'd1;
  localparam logic [1:0] CFG_IDLE_TIMEOUT     = 2'd2;
  localparam logic [1:0] CFG_HB_INTERVAL      = 2'd3;

  typedef enum logic [3:0] {
    EV_REJECTED     = 4'd0,
    EV_ACCEPTED     = 4'd1,
    EV_JOIN_RESP    = 4'd2,
    EV_HEARTBEAT    = 4'd3,
    EV_CONNECTED    = 4'd4,
    EV_DISCONNECTED = 4'd5,
    EV_DELIVER      = 4'd6,
    EV_BROWSE       = 4'd7,
    EV_TICK_DONE    = 4'd8
  } event_e;

  typedef enum logic [1:0] {
    CEV_NONE,
    CEV_HEARTBEAT,
    CEV_DISCONNECT
  } cell_ev_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_DECIDE,
    S_CONNECTED,
    S_TICK,
    S_SCAN,
    S_FLUSH
  } state_e;

  typedef struct packed {
    logic tick;
    logic alloc;
    logic drop;
    cfg_t timeout;
  } pend_ctl_t;

  typedef struct packed {
    logic tick;
    logic alloc;
    logic clr_rx;
    logic advance;
    num_t number;
    cfg_t idle_timeout;
    cfg_t hb_interval;
  } conn_ctl_t;

  typedef struct packed {
    event_e           ev;
    logic [31:0]      ip;
    logic [15:0]      port;
    num_t             id;
    logic             code;
    logic [CNT_W-1:0] count;
    logic             last;
  } res_t;

  // Saturating increment.
  function automatic age_t age_inc(age_t a);
    return (a == '1) ? a : age_t'(a + 1'b1);
  endfunction

  function automatic logic age_ge(age_t a, cfg_t lim);
    return CMP_W'(a) >= CMP_W'(lim);
  endfunction

endpackage

FILE: hw/rtl/utp_pend_cell.sv
// One pending-join slot: peer key, age and valid bit.
module utp_pend_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  utp_pkg::peer_t      key_i,
  input  utp_pkg::pend_ctl_t  ctl_i,
  output logic                valid_o,
  output logic                match_o
);

  logic           valid_q, valid_d;
  utp_pkg::peer_t peer_q;
  utp_pkg::age_t  age_q, age_next;

  always_comb begin
    age_next = utp_pkg::age_inc(age_q);
    valid_d  = valid_q;
    if (ctl_i.alloc) begin
      valid_d = 1'b1;
    end else if (ctl_i.drop) begin
      valid_d = 1'b0;
    end else if (ctl_i.tick && valid_q && utp_pkg::age_ge(age_next, ctl_i.timeout)) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.alloc) begin
      peer_q <= key_i;
      age_q  <= '0;
    end else if (ctl_i.tick && valid_q) begin
      age_q <= age_next;
    end
  end

  assign valid_o = valid_q;
  assign match_o = valid_q && (peer_q == key_i);

endmodule

FILE: hw/rtl/utp_conn_cell.sv
// One connected-peer slot; a scan token walks the row of these cells.
module utp_conn_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  utp_pkg::peer_t      key_i,
  input  utp_pkg::conn_ctl_t  ctl_i,
  input  logic                tok_i,
  output logic                tok_o,
  output logic                valid_o,
  output logic                match_o,
  output utp_pkg::cell_ev_e   ev_o,
  output utp_pkg::peer_t      peer_o,
  output utp_pkg::num_t       number_o
);

  logic              valid_q, valid_d;
  logic              tok_q, tok_d;
  utp_pkg::cell_ev_e ev_q, ev_d;
  utp_pkg::peer_t    peer_q;
  utp_pkg::num_t     number_q;
  utp_pkg::age_t     rx_q, tx_q, rx_next, tx_next;
  logic              stale, beat;

  always_comb begin
    rx_next = utp_pkg::age_inc(rx_q);
    tx_next = utp_pkg::age_inc(tx_q);
    stale   = utp_pkg::age_ge(rx_next, ctl_i.idle_timeout);
    beat    = utp_pkg::age_ge(tx_next, ctl_i.hb_interval);
    valid_d = valid_q;
    if (ctl_i.alloc) begin
      valid_d = 1'b1;
    end else if (ctl_i.tick && valid_q && stale) begin
      valid_d = 1'b0;
    end
    ev_d = ev_q;
    if (ctl_i.tick) begin
      if (!valid_q) begin
        ev_d = utp_pkg::CEV_NONE;
      end else if (stale) begin
        ev_d = utp_pkg::CEV_DISCONNECT;
      end else if (beat) begin
        ev_d = utp_pkg::CEV_HEARTBEAT;
      end else begin
        ev_d = utp_pkg::CEV_NONE;
      end
    end else if (tok_q && ctl_i.advance) begin
      // drop the event once the token moves on
      ev_d = utp_pkg::CEV_NONE;
    end
    tok_d = ctl_i.advance ? tok_i : tok_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= 1'b0;
      ev_q    <= utp_pkg::CEV_NONE;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
      ev_q    <= ev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.alloc) begin
      peer_q   <= key_i;
      number_q <= ctl_i.number;
      rx_q     <= '0;
      tx_q     <= '0;
    end else begin
      if (ctl_i.clr_rx) begin
        rx_q <= '0;
      end
      if (ctl_i.tick && valid_q) begin
        rx_q <= rx_next;
        if (!stale) begin
          tx_q <= beat ? '0 : tx_next;
        end
      end
    end
  end

  assign tok_o    = tok_q;
  assign valid_o  = valid_q;
  assign match_o  = valid_q && (peer_q == key_i);
  assign ev_o     = tok_q ? ev_q : utp_pkg::CEV_NONE;
  assign peer_o   = peer_q;
  assign number_o = number_q;

endmodule

FILE: hw/rtl/udp_connection_tracker_top.sv
// Top level of the UDP connection tracker: control, cell rows and result register.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+------------------------------------
//  in       | sink      | in_valid_i / in_stall_o  | command, src_ip/port, msg_type, ...
//  out      | source    | out_valid_o / out_stall_i| event_res, dest_ip/port, conn_id, ...
//  cfg      | sink      | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// A packet runs in steps (a join ack gives two results): match the key
// against all cells, register the hits, then decide and write the result register.
// A tick ages every cell at once in S_TICK, then the scan token walks the connected
// cells one per cycle while no output stall holds it, then a flush.
// Output stalls hold the sequence wherever a result is waiting to be placed.
// Reset clears valid bits, counters, state and config registers to their defaults.
`include "udp_connection_tracker_top_assert.svh"

module udp_connection_tracker_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [31:0] src_ip_i,
  input  logic [15:0] src_port_i,
  input  logic [2:0]  msg_type_i,
  input  logic        out_of_band_i,
  input  logic [15:0] join_version_i,
  input  logic        checks_passed_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  event_res_o,
  output logic [31:0] dest_ip_o,
  output logic [15:0] dest_port_o,
  output logic [31:0] conn_id_o,
  output logic        join_code_o,
  output logic [4:0]  player_count_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int PS = utp_pkg::PENDING_SLOTS;
  localparam int CS = utp_pkg::CONNECTION_SLOTS;

  utp_pkg::state_e state_q, state_d;

  utp_pkg::cfg_t proto_q, pend_to_q, idle_to_q, hb_q;

  utp_pkg::peer_t key_q;
  logic [2:0]     type_q;
  logic           oob_q, chk_q;
  logic [15:0]    ver_q;

  logic [PS-1:0] pvalid, pmatch, phit_q, pfree, pfree_oh, pend_alloc, pend_drop;
  logic [CS-1:0] cvalid, cmatch, chit_q, cfree, cfree_oh, conn_alloc, conn_clr, tok;
  logic [CS:0]   tok_chain;

  utp_pkg::cell_ev_e    cev [CS];
  utp_pkg::peer_t       cpeer [CS];
  utp_pkg::num_t        cnum [CS];

  utp_pkg::pend_ctl_t   pctl [PS];
  utp_pkg::conn_ctl_t   cctl [CS];

  logic                        tick, advance, scan_start;
  utp_pkg::num_t               last_q, last_d, new_num, hit_num, tok_num;
  utp_pkg::peer_t              tok_peer;
  logic [1:0]                  cur_ev;
  logic [utp_pkg::CNT_W-1:0]   cnt_q, cnt_d;

  utp_pkg::res_t out_q, held_q, held_d, push_res, base;
  logic          out_valid_q, held_valid_q, held_valid_d, push, out_free, in_acc;

  assign in_stall_o  = (state_q != utp_pkg::S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proto_q   <= utp_pkg::cfg_t'(1);
      pend_to_q <= utp_pkg::cfg_t'(5000);
      idle_to_q <= utp_pkg::cfg_t'(5000);
      hb_q      <= utp_pkg::cfg_t'(1000);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        utp_pkg::CFG_PROTOCOL_VERSION: proto_q   <= cfg_data_i;
        utp_pkg::CFG_PENDING_TIMEOUT:  pend_to_q <= cfg_data_i;
        utp_pkg::CFG_IDLE_TIMEOUT:     idle_to_q <= cfg_data_i;
        utp_pkg::CFG_HB_INTERVAL:      hb_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // latch the input word and, in S_MATCH, the cell match hits
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_q  <= {src_ip_i, src_port_i};
      type_q <= msg_type_i;
      oob_q  <= out_of_band_i;
      ver_q  <= join_version_i;
      chk_q  <= checks_passed_i;
    end
    if (state_q == utp_pkg::S_MATCH) begin
      phit_q <= pmatch;
      chit_q <= cmatch;
    end
  end

  // pending row
  for (genvar i = 0; i < PS; i++) begin : g_pend
    assign pctl[i] = '{tick: tick, alloc: pend_alloc[i], drop: pend_drop[i],
                       timeout: pend_to_q};
    utp_pend_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .key_i   (key_q),
      .ctl_i   (pctl[i]),
      .valid_o (pvalid[i]),
      .match_o (pmatch[i])
    );
  end

  // connected row; the scan token enters at slot 0
  assign tok_chain[0] = scan_start;
  for (genvar i = 0; i < CS; i++) begin : g_conn
    assign cctl[i] = '{tick: tick, alloc: conn_alloc[i], clr_rx: conn_clr[i],
                       advance: advance, number: new_num, idle_timeout: idle_to_q,
                       hb_interval: hb_q};
    utp_conn_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .key_i    (key_q),
      .ctl_i    (cctl[i]),
      .tok_i    (tok_chain[i]),
      .tok_o    (tok_chain[i+1]),
      .valid_o  (cvalid[i]),
      .match_o  (cmatch[i]),
      .ev_o     (cev[i]),
      .peer_o   (cpeer[i]),
      .number_o (cnum[i])
    );
    assign tok[i] = tok_chain[i+1];
  end

  assign pfree    = ~pvalid;
  assign pfree_oh = pfree & (~pfree + 1'b1);
  assign cfree    = ~cvalid;
  assign cfree_oh = cfree & (~cfree + 1'b1);
  assign new_num  = last_q + 1'b1;

  always_comb begin
    hit_num  = '0;
    tok_num  = '0;
    tok_peer = '0;
    cur_ev   = '0;
    for (int i = 0; i < CS; i++) begin
      hit_num  = hit_num | (chit_q[i] ? cnum[i] : '0);
      tok_num  = tok_num | (tok[i] ? cnum[i] : '0);
      tok_peer = tok_peer | (tok[i] ? cpeer[i] : '0);
      cur_ev   = cur_ev | cev[i];
    end
  end

  always_comb begin
    base       = '0;
    base.ev    = utp_pkg::EV_REJECTED;
    base.ip    = key_q[47:16];
    base.port  = key_q[15:0];
    base.last  = 1'b1;

    state_d      = state_q;
    push         = 1'b0;
    push_res     = base;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    cnt_d        = cnt_q;
    last_d       = last_q;
    pend_alloc   = '0;
    pend_drop    = '0;
    conn_alloc   = '0;
    conn_clr     = '0;
    tick         = 1'b0;
    advance      = 1'b0;
    scan_start   = 1'b0;

    unique case (state_q)
      utp_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = (command_i == utp_pkg::CMD_TICK) ? utp_pkg::S_TICK : utp_pkg::S_MATCH;
        end
      end
      utp_pkg::S_MATCH: begin
        state_d = utp_pkg::S_DECIDE;
      end
      utp_pkg::S_DECIDE: begin
        if (out_free) begin
          push    = 1'b1;
          state_d = utp_pkg::S_IDLE;
          if (!chk_q) begin
            push_res = base;
          end else if (!oob_q) begin
            if (|chit_q && type_q == utp_pkg::MSG_HEARTBEAT) begin
              conn_clr    = chit_q;
              push_res.ev = utp_pkg::EV_ACCEPTED;
              push_res.id = hit_num;
            end else if (|chit_q && type_q == utp_pkg::MSG_PAYLOAD) begin
              push_res.ev = utp_pkg::EV_DELIVER;
              push_res.id = hit_num;
            end
          end else if (|phit_q) begin
            if (type_q == utp_pkg::MSG_JOIN_ACK && |cfree) begin
              // promote: heartbeat now, connected event next
              pend_drop     = phit_q;
              conn_alloc    = cfree_oh;
              last_d        = new_num;
              cnt_d         = utp_pkg::CNT_W'(cnt_q + 1'b1);
              push_res.ev   = utp_pkg::EV_HEARTBEAT;
              push_res.id   = new_num;
              push_res.last = 1'b0;
              state_d       = utp_pkg::S_CONNECTED;
            end
          end else if (|chit_q) begin
            push_res = base;
          end else if (type_q == utp_pkg::MSG_JOIN_REQ) begin
            if (|pfree) begin
              pend_alloc    = pfree_oh;
              push_res.ev   = utp_pkg::EV_JOIN_RESP;
              push_res.code = (ver_q != proto_q);
            end
          end else if (type_q == utp_pkg::MSG_LIST_REQ) begin
            push_res.ev    = utp_pkg::EV_BROWSE;
            push_res.count = cnt_q;
          end
        end
      end
      utp_pkg::S_CONNECTED: begin
        if (out_free) begin
          push        = 1'b1;
          push_res.ev = utp_pkg::EV_CONNECTED;
          push_res.id = last_q;
          state_d     = utp_pkg::S_IDLE;
        end
      end
      utp_pkg::S_TICK: begin
        tick       = 1'b1;
        advance    = 1'b1;
        scan_start = 1'b1;
        state_d    = utp_pkg::S_SCAN;
      end
      utp_pkg::S_SCAN: begin
        // hold the token while a found event cannot displace the held one
        if (!(cur_ev != utp_pkg::CEV_NONE && held_valid_q && !out_free)) begin
          advance = 1'b1;
          if (cur_ev != utp_pkg::CEV_NONE) begin
            if (held_valid_q) begin
              push     = 1'b1;
              push_res = held_q;
            end
            held_valid_d = 1'b1;
            held_d       = '0;
            held_d.ip    = tok_peer[47:16];
            held_d.port  = tok_peer[15:0];
            held_d.id    = tok_num;
            if (cur_ev == utp_pkg::CEV_DISCONNECT) begin
              held_d.ev = utp_pkg::EV_DISCONNECTED;
              cnt_d     = utp_pkg::CNT_W'(cnt_q - 1'b1);
            end else begin
              held_d.ev = utp_pkg::EV_HEARTBEAT;
            end
          end
          if (tok[CS-1]) begin
            state_d = utp_pkg::S_FLUSH;
          end
        end
      end
      utp_pkg::S_FLUSH: begin
        if (out_free) begin
          push = 1'b1;
          if (held_valid_q) begin
            push_res      = held_q;
            push_res.last = 1'b1;
          end else begin
            push_res    = '0;
            push_res.ev = utp_pkg::EV_TICK_DONE;
            push_res.last = 1'b1;
          end
          held_valid_d = 1'b0;
          state_d      = utp_pkg::S_IDLE;
        end
      end
      default: state_d = utp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= utp_pkg::S_IDLE;
      cnt_q        <= '0;
      last_q       <= '0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      last_q       <= last_d;
      held_valid_q <= held_valid_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
    if (push) begin
      out_q <= push_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_res_o    = out_q.ev;
  assign dest_ip_o      = out_q.ip;
  assign dest_port_o    = out_q.port;
  assign conn_id_o      = out_q.id;
  assign join_code_o    = out_q.code;
  assign player_count_o = 5'(out_q.count);
  assign last_o         = out_q.last;

  `UTP_ASSERT(a_one_token, $onehot0(tok))
  `UTP_ASSERT(a_count_matches, (state_q != utp_pkg::S_IDLE) || ($countones(cvalid) == cnt_q))
  `UTP_ASSERT(a_held_in_tick, !held_valid_q || state_q == utp_pkg::S_SCAN || state_q == utp_pkg::S_FLUSH)
  `UTP_ASSERT_NEXT(a_ack_follows, state_q == utp_pkg::S_DECIDE && state_d == utp_pkg::S_CONNECTED, out_valid_q && !out_q.last)
  `UTP_ASSERT(a_no_push_when_full, !push || out_free)

endmodule
